// ===== rtl/beacon_frame_builder_assert.svh =====
// Assertion macros used by the beacon frame builder checker.
// Each macro expects a clock and an active-low reset name to be passed in.
`ifndef BEACON_FRAME_BUILDER_ASSERT_SVH
`define BEACON_FRAME_BUILDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFB_ASSERT_NOW(label, clk_s, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFB_ASSERT_NEXT(label, clk_s, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/bfb_pkg.sv =====
// Package for the beacon frame builder: stream layout, frame constants,
// microcode word format and the control program. Depends on nothing.
package bfb_pkg;

	localparam int MAX_SSID_BYTES = 32;

	localparam int IN_W       = 384;
	localparam int OUT_W      = 40;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	localparam int IN_BSSID_LSB = 0;
	localparam int IN_TS_LSB    = 48;
	localparam int IN_LEN_LSB   = 112;
	localparam int IN_SSID_LSB  = 118;
	localparam int IN_IDX_LSB   = 374;

	localparam int HDR_BYTES   = 38;
	localparam int TAIL_BYTES  = 13;
	localparam int FIXED_BYTES = HDR_BYTES + TAIL_BYTES;

	localparam logic [3:0] CHANNEL_RESET = 4'd1;

	localparam logic [7:0] FC_BEACON     = 8'h80;
	localparam logic [7:0] BCAST_BYTE    = 8'hFF;
	localparam logic [7:0] INTERVAL_LO   = 8'h64;
	localparam logic [7:0] CAP_ESS       = 8'h01;
	localparam logic [7:0] TAG_SSID      = 8'h00;
	localparam logic [7:0] TAG_RATES     = 8'h01;
	localparam logic [7:0] TAG_DS        = 8'h03;
	localparam logic [7:0] LOCAL_ADMIN   = 8'h02;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHANNEL = 2'd0,
		REG_HIDDEN  = 2'd1,
		REG_DERIVE  = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		COND_IN_ACCEPT = 2'd0,
		COND_HASH_DONE = 2'd1,
		COND_ALWAYS    = 2'd2,
		COND_EMIT_LAST = 2'd3
	} cond_t;

	typedef logic [1:0] upc_t;

	localparam upc_t UPC_IDLE  = 2'd0;
	localparam upc_t UPC_HASH  = 2'd1;
	localparam upc_t UPC_BUILD = 2'd2;
	localparam upc_t UPC_EMIT  = 2'd3;

	typedef struct packed {
		logic  in_ready;
		logic  load;
		logic  hash_en;
		logic  build;
		logic  emit;
		cond_t cond;
		upc_t  target;
	} uword_t;

	typedef struct packed {
		logic in_accept;
		logic hash_done;
		logic emit_last;
	} ustat_t;

	function automatic uword_t ucode_rom(upc_t pc);
		uword_t w;
		w = '0;
		unique case (pc)
			UPC_IDLE: begin
				w.in_ready = 1'b1;
				w.load     = 1'b1;
				w.cond     = COND_IN_ACCEPT;
				w.target   = UPC_HASH;
			end
			UPC_HASH: begin
				w.hash_en = 1'b1;
				w.cond    = COND_HASH_DONE;
				w.target  = UPC_BUILD;
			end
			UPC_BUILD: begin
				w.build  = 1'b1;
				w.cond   = COND_ALWAYS;
				w.target = UPC_EMIT;
			end
			UPC_EMIT: begin
				w.emit   = 1'b1;
				w.cond   = COND_EMIT_LAST;
				w.target = UPC_IDLE;
			end
		endcase
		return w;
	endfunction

	// Tagged tail: supported rates tag, then the DS parameter tag.
	function automatic logic [7:0] tail_byte(logic [3:0] idx, logic [3:0] chan);
		logic [7:0] b;
		unique case (idx)
			4'd0:    b = TAG_RATES;
			4'd1:    b = 8'h08;
			4'd2:    b = 8'h82;
			4'd3:    b = 8'h84;
			4'd4:    b = 8'h8B;
			4'd5:    b = 8'h96;
			4'd6:    b = 8'h0C;
			4'd7:    b = 8'h12;
			4'd8:    b = 8'h18;
			4'd9:    b = 8'h24;
			4'd10:   b = TAG_DS;
			4'd11:   b = 8'h01;
			4'd12:   b = {4'd0, chan};
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/bfb_useq.sv =====
// Microcode sequencer of the beacon frame builder: step counter and control ROM.
// Depends on bfb_pkg for the control word format and the program.
module bfb_useq
	import bfb_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  ustat_t stat,
	output uword_t ctrl
);

	upc_t upc_q;
	logic cond_met;

	assign ctrl = ucode_rom(upc_q);

	always_comb begin
		unique case (ctrl.cond)
			COND_IN_ACCEPT: cond_met = stat.in_accept;
			COND_HASH_DONE: cond_met = stat.hash_done;
			COND_ALWAYS:    cond_met = 1'b1;
			COND_EMIT_LAST: cond_met = stat.emit_last;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UPC_IDLE;
		end else if (cond_met) begin
			upc_q <= ctrl.target;
		end
	end

endmodule

// ===== rtl/bfb_datapath.sv =====
// Datapath of the beacon frame builder: request registers, SSID hash, header
// assembly, word composer and output register. Depends on bfb_pkg.
module bfb_datapath
	import bfb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  uword_t                ctrl,
	output ustat_t                stat,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	input  logic [IN_W-1:0]       s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_W-1:0]      m_axis_tdata,
	output logic                  m_axis_tlast
);

	logic [3:0]  channel_q;
	logic        hidden_q;
	logic        derive_q;

	logic [7:0]  ssid_q [MAX_SSID_BYTES];
	logic [47:0] bssid_q;
	logic [63:0] ts_q;
	logic [5:0]  len_q;
	logic [7:0]  idx_q;
	logic [5:0]  cnt_q;
	logic [31:0] hash_q;
	logic [11:0] seq_q;
	logic [7:0]  hdr_d [HDR_BYTES];
	logic [7:0]  addr_b [6];
	logic [5:0]  leff_q;
	logic [6:0]  nbytes_q;
	logic [4:0]  word_q;

	logic [31:0] out_word_q;
	logic [2:0]  out_cnt_q;
	logic        out_last_q;
	logic        out_valid_q;

	logic        in_accept;
	logic        hash_done;
	logic        emit_fire;
	logic [5:0]  len_in;
	logic [5:0]  leff_d;
	logic [6:0]  pos [4];
	logic [6:0]  ssid_end;
	logic [6:0]  rel [4];
	logic [6:0]  tail_rel [4];
	logic [7:0]  lane_b [4];
	logic [6:0]  word_base;
	logic [6:0]  remain;
	logic [2:0]  word_cnt;
	logic        word_last;
	logic [31:0] word_d;

	assign in_accept = s_axis_tvalid && ctrl.in_ready;
	assign hash_done = !derive_q || (cnt_q == len_q);
	assign emit_fire = ctrl.emit && (!out_valid_q || m_axis_tready);

	assign stat.in_accept = in_accept;
	assign stat.hash_done = hash_done;
	assign stat.emit_last = emit_fire && word_last;

	assign len_in = (s_axis_tdata[IN_LEN_LSB +: 6] > 6'(MAX_SSID_BYTES)) ?
		6'(MAX_SSID_BYTES) : s_axis_tdata[IN_LEN_LSB +: 6];
	assign leff_d = hidden_q ? 6'd0 : len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_q <= CHANNEL_RESET;
			hidden_q  <= 1'b0;
			derive_q  <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CHANNEL: channel_q <= cfg_data[3:0];
				REG_HIDDEN:  hidden_q  <= cfg_data[0];
				REG_DERIVE:  derive_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load && in_accept) begin
			for (int i = 0; i < MAX_SSID_BYTES; i++) begin
				ssid_q[i] <= s_axis_tdata[IN_SSID_LSB + 8*i +: 8];
			end
			bssid_q <= s_axis_tdata[IN_BSSID_LSB +: 48];
			ts_q    <= s_axis_tdata[IN_TS_LSB +: 64];
			idx_q   <= s_axis_tdata[IN_IDX_LSB +: 8];
			len_q   <= len_in;
			cnt_q   <= 6'd0;
			hash_q  <= 32'd0;
		end else if (ctrl.hash_en && !hash_done) begin
			hash_q <= (hash_q << 5) - hash_q + {24'd0, ssid_q[cnt_q[4:0]]};
			cnt_q  <= cnt_q + 6'd1;
		end
		if (ctrl.build) begin
			leff_q   <= leff_d;
			nbytes_q <= 7'(FIXED_BYTES) + {1'b0, leff_d};
		end
	end

	always_comb begin
		if (derive_q) begin
			addr_b[0] = LOCAL_ADMIN;
			addr_b[1] = hash_q[31:24];
			addr_b[2] = hash_q[23:16];
			addr_b[3] = hash_q[15:8];
			addr_b[4] = hash_q[7:0];
			addr_b[5] = idx_q + 8'd1;
		end else begin
			for (int i = 0; i < 6; i++) begin
				addr_b[i] = bssid_q[8*i +: 8];
			end
		end
		hdr_d[0] = FC_BEACON;
		hdr_d[1] = 8'h00;
		hdr_d[2] = 8'h00;
		hdr_d[3] = 8'h00;
		for (int i = 0; i < 6; i++) begin
			hdr_d[4 + i]  = BCAST_BYTE;
			hdr_d[10 + i] = addr_b[i];
			hdr_d[16 + i] = addr_b[i];
		end
		hdr_d[22] = {seq_q[3:0], 4'd0};
		hdr_d[23] = seq_q[11:4];
		for (int i = 0; i < 8; i++) begin
			hdr_d[24 + i] = ts_q[8*i +: 8];
		end
		hdr_d[32] = INTERVAL_LO;
		hdr_d[33] = 8'h00;
		hdr_d[34] = CAP_ESS;
		hdr_d[35] = 8'h00;
		hdr_d[36] = TAG_SSID;
		hdr_d[37] = {2'd0, leff_d};
	end

	// The sequence number advances once the last beat of a frame is loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= 12'd0;
		end else if (emit_fire && word_last) begin
			seq_q <= seq_q + 12'd1;
		end
	end

	// Each lane picks its byte from the header, the SSID or the tagged tail, or zero past the frame end.
	assign ssid_end  = 7'(HDR_BYTES) + {1'b0, leff_q};
	assign word_base = {word_q, 2'b00};
	assign remain    = nbytes_q - word_base;
	assign word_last = (remain <= 7'd4);
	assign word_cnt  = word_last ? remain[2:0] : 3'd4;

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			pos[l]      = {word_q, 2'(l)};
			rel[l]      = pos[l] - 7'(HDR_BYTES);
			tail_rel[l] = pos[l] - ssid_end;
			if (pos[l] < 7'(HDR_BYTES)) begin
				lane_b[l] = hdr_d[pos[l][5:0]];
			end else if (pos[l] < ssid_end) begin
				lane_b[l] = ssid_q[rel[l][4:0]];
			end else if (pos[l] < nbytes_q) begin
				lane_b[l] = tail_byte(tail_rel[l][3:0], channel_q);
			end else begin
				lane_b[l] = 8'h00;
			end
		end
		word_d = {lane_b[3], lane_b[2], lane_b[1], lane_b[0]};
	end

	always_ff @(posedge clk) begin
		if (ctrl.build) begin
			word_q <= 5'd0;
		end else if (emit_fire) begin
			word_q <= word_q + 5'd1;
		end
		if (emit_fire) begin
			out_word_q <= word_d;
			out_cnt_q  <= word_cnt;
			out_last_q <= word_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, out_cnt_q, out_word_q};
	assign m_axis_tlast  = out_last_q;

endmodule

// ===== rtl/beacon_frame_builder.sv =====
// Beacon frame builder: one request in, one frame of 13 to 21 words out.
// Per request: a hash step for each SSID byte (none when the BSSID is not derived),
// one hash exit step, one header build step, then one word per cycle as the output
// register drains.
// A new request is taken once the last word sits in the output register.
// Asynchronous reset clears the step counter, the sequence number, the output valid
// flag and sets channel 1, SSID shown and derived BSSID.
module beacon_frame_builder
	import bfb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// From bit 0: bssid[47:0], timestamp_us[111:48], ssid_len[117:112],
	// ssid_bytes_a[181:118], ssid_bytes_b[245:182], ssid_bytes_c[309:246],
	// ssid_bytes_d[373:310], entry_index[381:374], zero fill.
	input  logic [IN_W-1:0]       s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// From bit 0: frame_word[31:0], byte_count[34:32], zero fill.
	output logic [OUT_W-1:0]      m_axis_tdata,
	output logic                  m_axis_tlast
);

	uword_t ctrl;
	ustat_t stat;

	assign s_axis_tready = ctrl.in_ready;

	bfb_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	bfb_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ===== rtl/bfb_checker.sv =====
// Port-level checker for the beacon frame builder, bound to the top level.
// Depends on bfb_pkg and beacon_frame_builder_assert.svh.
`include "beacon_frame_builder_assert.svh"

module bfb_checker
	import bfb_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_W-1:0]      m_axis_tdata,
	input logic                  m_axis_tlast
);

	`BFB_ASSERT_NOW(a_count_range, clk, arst_n, m_axis_tvalid,
		(m_axis_tdata[34:32] != 3'd0) && (m_axis_tdata[34:32] <= 3'd4),
		"beat byte count outside 1 to 4")

	`BFB_ASSERT_NOW(a_full_inner, clk, arst_n, m_axis_tvalid && !m_axis_tlast,
		m_axis_tdata[34:32] == 3'd4, "beat before the last is not full")

	`BFB_ASSERT_NOW(a_pad_zero, clk, arst_n, m_axis_tvalid && (m_axis_tdata[34:32] == 3'd3),
		m_axis_tdata[31:24] == 8'h00, "unused byte of a partial beat is not zero")

	`BFB_ASSERT_NEXT(a_one_request, clk, arst_n, s_axis_tvalid && s_axis_tready,
		!s_axis_tready, "request accepted while the previous one is in work")

	`BFB_ASSERT_NEXT(a_hold_stall, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
		"stalled output beat changed")

endmodule

bind beacon_frame_builder bfb_checker u_bfb_checker (.*);

// ===== sim/tb_top.sv =====
// Self-checking testbench for beacon_frame_builder: directed table, then random requests
// under several idle and stall mixes, every frame word checked against a local frame builder.
// Depends on bfb_pkg and the beacon_frame_builder RTL.
module tb_top;
	import bfb_pkg::*;

	localparam int WATCHDOG_LIMIT = 1500;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 40;
	localparam int BLOCK_ITEMS    = 25;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [7:0] RATES_IE [10] = '{8'h01, 8'h08, 8'h82, 8'h84, 8'h8B,
		8'h96, 8'h0C, 8'h12, 8'h18, 8'h24};

	typedef struct packed {
		logic [7:0]  entry_index;
		logic [63:0] ssid_d;
		logic [63:0] ssid_c;
		logic [63:0] ssid_b;
		logic [63:0] ssid_a;
		logic [5:0]  ssid_len;
		logic [63:0] timestamp_us;
		logic [47:0] bssid;
	} beacon_req_t;

	typedef struct packed {
		logic [31:0] frame_word;
		logic [2:0]  byte_count;
		logic        last_word;
	} frame_beat_t;

	// A nonzero word count marks a frame whose length and closing beat are typed in.
	typedef struct {
		int          words;
		logic [31:0] last_word;
		logic [2:0]  last_count;
	} frame_note_t;

	typedef enum {ROW_REG, ROW_REQ} row_kind_t;

	typedef struct {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   reg_idx;
		logic [CFG_DATA_W-1:0]  reg_val;
		beacon_req_t            req;
		frame_note_t            note;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_W-1:0]       s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_W-1:0]      m_axis_tdata;
	logic                  m_axis_tlast;

	logic [3:0]  chan_r;
	logic        hidden_r;
	logic        derive_r;
	logic [11:0] seq_num;

	frame_beat_t frame_q [$];
	frame_note_t note_q [$];
	dir_row_t    dir_tab [$];

	int  mismatches;
	int  sender_idle_pct;
	int  recv_stall_pct;
	int  stuck_cycles;
	int  words_in_frame;
	bit  hold_req;

	beacon_frame_builder u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < 40)
			$display("MISMATCH %s: got %h, expected %h", what, got, want);
		mismatches++;
	endtask

	// Builds the whole beacon frame for one request and queues its beats.
	function automatic void predict_frame(input beacon_req_t r);
		logic [7:0]   fb [96];
		logic [7:0]   addr [6];
		logic [7:0]   ssid [32];
		logic [255:0] ssid_all;
		logic [31:0]  h;
		frame_beat_t  b;
		int n, len, nw, cnt;
		n = 0;
		h = '0;
		ssid_all = {r.ssid_d, r.ssid_c, r.ssid_b, r.ssid_a};
		for (int i = 0; i < 32; i++)
			ssid[i] = ssid_all[8*i +: 8];
		len = (r.ssid_len > MAX_SSID_BYTES) ? MAX_SSID_BYTES : int'(r.ssid_len);
		if (derive_r) begin
			for (int i = 0; i < len; i++)
				h = h * 32'd31 + 32'(ssid[i]);
			addr[0] = 8'h02;
			addr[1] = h[31:24];
			addr[2] = h[23:16];
			addr[3] = h[15:8];
			addr[4] = h[7:0];
			addr[5] = r.entry_index + 8'd1;
		end else begin
			for (int i = 0; i < 6; i++)
				addr[i] = r.bssid[8*i +: 8];
		end
		fb[n++] = 8'h80;
		fb[n++] = 8'h00;
		fb[n++] = 8'h00;
		fb[n++] = 8'h00;
		for (int i = 0; i < 6; i++)
			fb[n++] = 8'hFF;
		for (int j = 0; j < 2; j++)
			for (int i = 0; i < 6; i++)
				fb[n++] = addr[i];
		fb[n++] = {seq_num[3:0], 4'h0};
		fb[n++] = seq_num[11:4];
		seq_num = seq_num + 12'd1;
		for (int i = 0; i < 8; i++)
			fb[n++] = r.timestamp_us[8*i +: 8];
		fb[n++] = 8'h64;
		fb[n++] = 8'h00;
		fb[n++] = 8'h01;
		fb[n++] = 8'h00;
		fb[n++] = 8'h00;
		if (hidden_r) begin
			fb[n++] = 8'h00;
		end else begin
			fb[n++] = 8'(len);
			for (int i = 0; i < len; i++)
				fb[n++] = ssid[i];
		end
		for (int i = 0; i < 10; i++)
			fb[n++] = RATES_IE[i];
		fb[n++] = 8'h03;
		fb[n++] = 8'h01;
		fb[n++] = {4'h0, chan_r};
		nw = (n + 3) / 4;
		for (int k = 0; k < nw; k++) begin
			cnt = n - 4 * k;
			if (cnt > 4)
				cnt = 4;
			b.frame_word = '0;
			for (int i = 0; i < cnt; i++)
				b.frame_word[8*i +: 8] = fb[4*k + i];
			b.byte_count = 3'(cnt);
			b.last_word = (k == nw - 1);
			frame_q.push_back(b);
		end
	endfunction

	function automatic beacon_req_t random_req();
		beacon_req_t r;
		r.bssid = 48'({$urandom, $urandom});
		r.timestamp_us = {$urandom, $urandom};
		if ($urandom_range(99) < 15)
			r.ssid_len = 6'($urandom_range(63, 33));
		else
			r.ssid_len = 6'($urandom_range(32));
		r.ssid_a = {$urandom, $urandom};
		r.ssid_b = {$urandom, $urandom};
		r.ssid_c = {$urandom, $urandom};
		r.ssid_d = {$urandom, $urandom};
		r.entry_index = 8'($urandom);
		return r;
	endfunction

	function automatic dir_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		dir_row_t row;
		row.kind = ROW_REG;
		row.reg_idx = idx;
		row.reg_val = val;
		row.req = '0;
		row.note = '{0, 32'h0, 3'd0};
		return row;
	endfunction

	function automatic dir_row_t req_row(input logic [47:0] bssid, input logic [63:0] ts,
			input logic [5:0] len, input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] c, input logic [63:0] d, input logic [7:0] idx,
			input int words, input logic [31:0] last_word, input logic [2:0] last_count);
		dir_row_t row;
		row.kind = ROW_REQ;
		row.reg_idx = REG_CHANNEL;
		row.reg_val = '0;
		row.req = '{idx, d, c, b, a, len, ts, bssid};
		row.note = '{words, last_word, last_count};
		return row;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val, input bit more);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_CHANNEL: chan_r = val;
			REG_HIDDEN:  hidden_r = val[0];
			REG_DERIVE:  derive_r = val[0];
			default: ;
		endcase
		@(posedge clk);
		if (!more)
			cfg_we <= 1'b0;
	endtask

	task automatic send_item(input beacon_req_t req, input bit keep, input frame_note_t note);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_W'(req);
		do @(posedge clk); while (!s_axis_tready);
		predict_frame(req);
		note_q.push_back(note);
		gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 6) : 0;
		if (!keep || gap != 0)
			s_axis_tvalid <= 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	task automatic wait_idle();
		while (frame_q.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: random stalls, or one long hold-off on request.
	always begin
		@(posedge clk);
		if (hold_req) begin
			m_axis_tready <= 1'b0;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_req = 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		frame_beat_t got;
		frame_beat_t want;
		frame_note_t note;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.frame_word = m_axis_tdata[31:0];
			got.byte_count = m_axis_tdata[34:32];
			got.last_word = m_axis_tlast;
			words_in_frame++;
			if (frame_q.size() == 0) begin
				report_mismatch("beat with nothing expected", got.frame_word, 32'h0);
			end else begin
				want = frame_q.pop_front();
				if (got.frame_word !== want.frame_word)
					report_mismatch("frame_word", got.frame_word, want.frame_word);
				if (got.byte_count !== want.byte_count)
					report_mismatch("byte_count", 32'(got.byte_count), 32'(want.byte_count));
				if (got.last_word !== want.last_word)
					report_mismatch("last_word", 32'(got.last_word), 32'(want.last_word));
			end
			if (got.last_word) begin
				if (note_q.size() != 0) begin
					note = note_q.pop_front();
					if (note.words != 0) begin
						if (words_in_frame != note.words)
							report_mismatch("frame length", words_in_frame, note.words);
						if (got.frame_word !== note.last_word)
							report_mismatch("closing word", got.frame_word, note.last_word);
						if (got.byte_count !== note.last_count)
							report_mismatch("closing count", 32'(got.byte_count),
								32'(note.last_count));
					end
				end
				words_in_frame = 0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
			if (stuck_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

	initial begin
		logic [3:0] ch;
		logic       hid;
		logic       der;
		int idle_mix [4];
		int stall_mix [4];
		bit next_is_reg;
		bit next_is_req;
		idle_mix = '{0, 47, 0, 18};
		stall_mix = '{0, 0, 47, 18};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_CHANNEL;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		chan_r = 4'd1;
		hidden_r = 1'b0;
		derive_r = 1'b1;
		seq_num = '0;
		mismatches = 0;
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		stuck_cycles = 0;
		words_in_frame = 0;
		hold_req = 1'b0;

		// Settings after reset: channel 1, SSID shown, derived BSSID.
		dir_tab.push_back(req_row(48'h0, 64'h0, 6'd0, 64'h0, 64'h0, 64'h0, 64'h0, 8'd0,
			13, 32'h0001_0103, 3'd3));
		dir_tab.push_back(req_row(48'h0, 64'h1, 6'd1, 64'h41, 64'h0, 64'h0, 64'h0, 8'd1,
			13, 32'h0101_0324, 3'd4));
		dir_tab.push_back(req_row(48'h0, 64'h2, 6'd2, 64'h4241, 64'h0, 64'h0, 64'h0, 8'd2,
			14, 32'h0000_0001, 3'd1));
		dir_tab.push_back(req_row(48'h0, 64'h3, 6'd3, 64'h43_4241, 64'h0, 64'h0, 64'h0, 8'd3,
			14, 32'h0000_0101, 3'd2));
		dir_tab.push_back(req_row('1, '1, 6'd32, '1, '1, '1, '1, 8'hFF,
			21, 32'h0001_0103, 3'd3));
		dir_tab.push_back(req_row(48'h0, 64'h5555_5555_5555_5555, 6'd63,
			64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 64'hA5A5_5A5A_0F0F_F0F0,
			64'h8000_0000_0000_0001, 8'h7F, 21, 32'h0001_0103, 3'd3));
		dir_tab.push_back(req_row(48'h0, 64'hAAAA_AAAA_AAAA_AAAA, 6'd33,
			64'h3131_3131_3131_3131, 64'h7A7A_7A7A_7A7A_7A7A, 64'h0, 64'hFF00_FF00_FF00_FF00,
			8'h80, 21, 32'h0001_0103, 3'd3));
		dir_tab.push_back(req_row(48'h0, 64'h0123_4567_89AB_CDEF, 6'd32,
			64'h0, 64'h0, 64'h0, 64'h0, 8'h10, 21, 32'h0001_0103, 3'd3));
		dir_tab.push_back(req_row(48'h0, 64'h8000_0000_0000_0000, 6'd5,
			64'h0000_006F_6C6C_6568, 64'h0, 64'h0, 64'h0, 8'h80, 0, 32'h0, 3'd0));
		dir_tab.push_back(reg_row(REG_DERIVE, 4'd0));
		dir_tab.push_back(req_row('1, 64'h0, 6'd5,
			64'h0000_006F_6C6C_6568, 64'h0, 64'h0, 64'h0, 8'd0, 0, 32'h0, 3'd0));
		dir_tab.push_back(req_row(48'hAB89_6745_2301, 64'hDEAD_BEEF_0000_0001, 6'd8,
			64'h4E45_5453_5347_4E49, 64'h0, 64'h0, 64'h0, 8'd7, 0, 32'h0, 3'd0));
		dir_tab.push_back(reg_row(REG_HIDDEN, 4'd1));
		dir_tab.push_back(req_row(48'h1234_5678_9ABC, 64'h77, 6'd20,
			64'h1111_2222_3333_4444, 64'h5555_6666_7777_8888, 64'h9999_AAAA, 64'h0, 8'd9,
			13, 32'h0001_0103, 3'd3));
		dir_tab.push_back(req_row(48'h0, 64'h0, 6'd0, 64'h0, 64'h0, 64'h0, 64'h0, 8'd0,
			13, 32'h0001_0103, 3'd3));
		dir_tab.push_back(reg_row(REG_DERIVE, 4'd1));
		dir_tab.push_back(req_row(48'h0, 64'h1234, 6'd32,
			64'hC3C3_3C3C_9696_6969, 64'h0102_0304_0506_0708, 64'hF0E1_D2C3_B4A5_9687,
			64'h7F7F_7F7F_7F7F_7F7F, 8'hFE, 13, 32'h0001_0103, 3'd3));
		dir_tab.push_back(reg_row(REG_CHANNEL, 4'd15));
		dir_tab.push_back(req_row(48'h0, 64'h99, 6'd10, 64'h6162_6364_6566_6768,
			64'h6A69, 64'h0, 64'h0, 8'd4, 13, 32'h000F_0103, 3'd3));
		dir_tab.push_back(reg_row(REG_CHANNEL, 4'd0));
		dir_tab.push_back(reg_row(REG_SPARE, 4'hF));
		dir_tab.push_back(reg_row(REG_HIDDEN, 4'hE));
		dir_tab.push_back(req_row(48'h0, 64'h42, 6'd4, 64'h7473_6574, 64'h0, 64'h0, 64'h0,
			8'd5, 14, 32'h0000_0103, 3'd3));
		dir_tab.push_back(reg_row(REG_CHANNEL, 4'd13));
		dir_tab.push_back(req_row(48'h0, 64'hFFFF_0000_FFFF_0000, 6'd7,
			64'h0061_6263_0064_6500, 64'h0, 64'h0, 64'h0, 8'd200, 0, 32'h0, 3'd0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < dir_tab.size(); r++) begin
			next_is_reg = (r + 1 < dir_tab.size()) && (dir_tab[r + 1].kind == ROW_REG);
			next_is_req = (r + 1 < dir_tab.size()) && (dir_tab[r + 1].kind == ROW_REQ);
			if (dir_tab[r].kind == ROW_REG) begin
				wait_idle();
				write_reg(dir_tab[r].reg_idx, dir_tab[r].reg_val, next_is_reg);
			end else begin
				send_item(dir_tab[r].req, next_is_req, dir_tab[r].note);
			end
		end

		for (int ph = 0; ph < 4; ph++) begin
			sender_idle_pct = idle_mix[ph];
			recv_stall_pct = stall_mix[ph];
			for (int blk = 0; blk < 4; blk++) begin
				wait_idle();
				case ($urandom_range(3))
					0:       ch = 4'd1;
					1:       ch = 4'd13;
					default: ch = 4'($urandom_range(15));
				endcase
				hid = ($urandom_range(3) == 0);
				der = 1'($urandom_range(1));
				write_reg(REG_CHANNEL, ch, 1'b1);
				write_reg(REG_HIDDEN, {3'($urandom), hid}, 1'b1);
				write_reg(REG_DERIVE, {3'($urandom), der}, 1'b0);
				// The receiver holds off while requests keep coming, so the block backs up.
				if (ph == 0 && blk == 1)
					hold_req = 1'b1;
				for (int i = 0; i < BLOCK_ITEMS; i++)
					send_item(random_req(), i != BLOCK_ITEMS - 1, '{0, 32'h0, 3'd0});
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (note_q.size() != 0)
			report_mismatch("frames never closed", note_q.size(), 32'h0);
		if (mismatches == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// ===== beacon_frame_builder.f =====
+incdir+rtl
rtl/bfb_pkg.sv
rtl/bfb_useq.sv
rtl/bfb_datapath.sv
rtl/beacon_frame_builder.sv
rtl/bfb_checker.sv
sim/tb_top.sv
